// File: sv/bcd_pkg.sv
package bcd_pkg;

    localparam int LEN_W = 11;
    localparam int LIM_W = 7;
    localparam int IDX_W = 10;
    // (limit + 1) * length, and suspicious * 100, share this width
    localparam int T_W = LIM_W + 1 + LEN_W;

    localparam logic [LEN_W-1:0] MAX_SCAN = 11'd1024;
    localparam int FIFO_DEPTH = 2;

    localparam logic [LEN_W-1:0] MIN_RESET = 11'd32;
    localparam logic [LIM_W-1:0] LIM_RESET = 7'd10;

    localparam logic CFG_MIN_IDX = 1'b0;
    localparam logic CFG_LIM_IDX = 1'b1;

    localparam logic [T_W-1:0] PCT_SCALE = 19'd100;

    localparam logic [7:0] BOM_B0 = 8'hEF;
    localparam logic [7:0] BOM_B1 = 8'hBB;
    localparam logic [7:0] BOM_B2 = 8'hBF;
    localparam logic [1:0] BOM_FAIL = 2'd3;

    localparam logic [7:0] CONT_LIMIT = 8'd192;
    localparam logic [7:0] LEAD2_HI = 8'd223;
    localparam logic [7:0] LEAD3_LO = 8'd224;
    localparam logic [7:0] LEAD3_HI = 8'd239;
    localparam logic [7:0] CTRL_LO = 8'd7;
    localparam logic [7:0] CTRL_HI = 8'd14;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd127;

    typedef enum logic [2:0] {
        CAUSE_BOM        = 3'd0,
        CAUSE_NULL       = 3'd1,
        CAUSE_EARLY      = 3'd2,
        CAUSE_FINAL_BIN  = 3'd3,
        CAUSE_FINAL_TEXT = 3'd4
    } t_cause;

    typedef enum logic [3:0] {
        UTF_NONE = 4'b0001,
        UTF_C2   = 4'b0010,
        UTF_C3A  = 4'b0100,
        UTF_C3B  = 4'b1000
    } t_utf;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] scan_length;
    } t_in_word;

    typedef struct packed {
        logic             verdict;
        t_cause           decision_cause;
        logic [IDX_W-1:0] decision_index;
    } t_out_word;

    // one classified byte, front to back
    typedef struct packed {
        logic             is_null;
        logic             is_susp;
        logic             hi;        // >= 192
        logic             lead2_ok;  // 2-byte lead with room for its tail
        logic             lead3_ok;
        logic             bom_hit;
        logic             pos_lt3;
        logic [1:0]       pos_lo;
        logic [IDX_W-1:0] pos_idx;
        logic             last;
        logic             len_ge3;
        logic             early_ok;
        logic [T_W-1:0]   thresh;
    } t_cls;

    function automatic logic [7:0] bom_byte(input logic [1:0] pos);
        logic [7:0] r;
        case (pos)
            2'd0:    r = BOM_B0;
            2'd1:    r = BOM_B1;
            2'd2:    r = BOM_B2;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/bcd_front.sv
module bcd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [bcd_pkg::LEN_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bcd_pkg::t_in_word                   i_in_data,
    input  logic                                i_q_full,
    output logic                                o_push,
    output bcd_pkg::t_cls                       o_cls
);

    localparam int LEN_W = bcd_pkg::LEN_W;
    localparam int LIM_W = bcd_pkg::LIM_W;
    localparam int T_W   = bcd_pkg::T_W;

    logic [LEN_W-1:0] r_min;
    logic [LIM_W-1:0] r_limit;
    logic [LEN_W-1:0] r_pos;
    logic [LEN_W-1:0] n_pos;

    logic [LEN_W-1:0] len_c;
    logic [LEN_W-1:0] len;
    logic [LEN_W:0]   pos1;
    logic [LEN_W:0]   pos2;
    logic [7:0]       b;
    logic [LIM_W:0]   lim1;
    logic             last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= bcd_pkg::MIN_RESET;
            r_limit <= bcd_pkg::LIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bcd_pkg::CFG_MIN_IDX: r_min   <= i_cfg_data;
                bcd_pkg::CFG_LIM_IDX: r_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        b     = i_in_data.data_byte;
        len_c = (i_in_data.scan_length > bcd_pkg::MAX_SCAN) ? bcd_pkg::MAX_SCAN
                                                            : i_in_data.scan_length;
        len   = (len_c == '0) ? LEN_W'(1) : len_c;
        pos1  = {1'b0, r_pos} + (LEN_W+1)'(1);
        pos2  = {1'b0, r_pos} + (LEN_W+1)'(2);
        last  = pos1 >= {1'b0, len};
        lim1  = {1'b0, r_limit} + (LIM_W+1)'(1);

        o_cls.is_null  = (b == 8'd0);
        o_cls.is_susp  = (b < bcd_pkg::CTRL_LO || b > bcd_pkg::CTRL_HI) &&
                         (b < bcd_pkg::PRINT_LO || b > bcd_pkg::PRINT_HI);
        o_cls.hi       = (b >= bcd_pkg::CONT_LIMIT);
        o_cls.lead2_ok = (b >= bcd_pkg::CONT_LIMIT) && (b <= bcd_pkg::LEAD2_HI) &&
                         (pos1 < {1'b0, len});
        o_cls.lead3_ok = (b >= bcd_pkg::LEAD3_LO) && (b <= bcd_pkg::LEAD3_HI) &&
                         (pos2 < {1'b0, len});
        o_cls.pos_lt3  = (r_pos < LEN_W'(3));
        o_cls.pos_lo   = r_pos[1:0];
        o_cls.bom_hit  = (b == bcd_pkg::bom_byte(r_pos[1:0]));
        o_cls.pos_idx  = r_pos[bcd_pkg::IDX_W-1:0];
        o_cls.last     = last;
        o_cls.len_ge3  = (len >= LEN_W'(3));
        o_cls.early_ok = (r_pos >= r_min);
        // binary when suspicious*100 >= (limit+1)*length
        o_cls.thresh   = T_W'(lim1) * T_W'(len);

        n_pos = last ? '0 : pos1[LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push) begin
            r_pos <= n_pos;
        end
    end

endmodule

// File: sv/bcd_queue.sv
module bcd_queue #(
    parameter int DEPTH = bcd_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bcd_pkg::t_cls i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output bcd_pkg::t_cls o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bcd_pkg::t_cls    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: sv/bcd_back.sv
module bcd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  bcd_pkg::t_cls      i_cls,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bcd_pkg::t_out_word o_out_data
);

    localparam int T_W = bcd_pkg::T_W;

    logic [T_W-1:0]     r_s100;   // suspicious count times 100
    bcd_pkg::t_utf      r_utf;
    logic               r_done;
    logic [1:0]         r_bom;
    logic               r_out_valid;
    bcd_pkg::t_out_word r_out;

    logic [T_W-1:0]     n_s100;
    bcd_pkg::t_utf      n_utf;
    logic               n_done;
    logic [1:0]         n_bom;

    logic               go;
    logic               emit;
    bcd_pkg::t_out_word res;
    logic               examine;
    logic               cont_inc;
    logic               susp_inc;
    logic [T_W-1:0]     s_a;
    logic [T_W-1:0]     s_b;

    assign go          = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_pop       = go;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_done   = r_done;
        n_utf    = r_utf;
        n_bom    = r_bom;
        emit     = 1'b0;
        examine  = 1'b0;
        cont_inc = 1'b0;
        susp_inc = 1'b0;
        res.verdict        = 1'b0;
        res.decision_cause = bcd_pkg::CAUSE_FINAL_TEXT;
        res.decision_index = i_cls.pos_idx;

        if (!r_done) begin
            if (i_cls.pos_lt3 && r_bom == i_cls.pos_lo) begin
                if (i_cls.bom_hit) begin
                    n_bom = i_cls.pos_lo + 2'd1;
                    if (i_cls.pos_lo == 2'd2 && i_cls.len_ge3) begin
                        emit               = 1'b1;
                        res.verdict        = 1'b0;
                        res.decision_cause = bcd_pkg::CAUSE_BOM;
                        n_utf              = bcd_pkg::UTF_NONE;
                        n_done             = 1'b1;
                    end
                end else begin
                    n_bom = bcd_pkg::BOM_FAIL;
                end
            end else if (i_cls.pos_lt3) begin
                n_bom = bcd_pkg::BOM_FAIL;
            end
        end

        if (!n_done) begin
            case (r_utf)
                bcd_pkg::UTF_C2: begin
                    cont_inc = i_cls.hi;
                    n_utf    = bcd_pkg::UTF_NONE;
                end
                bcd_pkg::UTF_C3A: begin
                    if (i_cls.hi) begin
                        cont_inc = 1'b1;
                        n_utf    = bcd_pkg::UTF_NONE;
                    end else begin
                        n_utf = bcd_pkg::UTF_C3B;
                    end
                end
                bcd_pkg::UTF_C3B: begin
                    n_utf = bcd_pkg::UTF_NONE;
                    if (i_cls.hi) begin
                        cont_inc = 1'b1;
                        examine  = 1'b1;
                    end
                end
                default: examine = 1'b1;
            endcase
        end

        // early test sees the broken-continuation count already bumped
        s_a = r_s100 + (cont_inc ? bcd_pkg::PCT_SCALE : '0);

        if (!n_done && examine) begin
            if (i_cls.early_ok && s_a >= i_cls.thresh) begin
                emit               = 1'b1;
                res.verdict        = 1'b1;
                res.decision_cause = bcd_pkg::CAUSE_EARLY;
                n_done             = 1'b1;
            end else if (i_cls.is_null) begin
                emit               = 1'b1;
                res.verdict        = 1'b1;
                res.decision_cause = bcd_pkg::CAUSE_NULL;
                n_done             = 1'b1;
            end else if (i_cls.is_susp) begin
                if (i_cls.lead2_ok) begin
                    n_utf = bcd_pkg::UTF_C2;
                end else if (i_cls.lead3_ok) begin
                    n_utf = bcd_pkg::UTF_C3A;
                end else begin
                    susp_inc = 1'b1;
                end
            end
        end

        s_b = s_a + (susp_inc ? bcd_pkg::PCT_SCALE : '0);

        if (!n_done && i_cls.last) begin
            emit   = 1'b1;
            n_done = 1'b1;
            if (s_b >= i_cls.thresh) begin
                res.verdict        = 1'b1;
                res.decision_cause = bcd_pkg::CAUSE_FINAL_BIN;
            end else begin
                res.verdict        = 1'b0;
                res.decision_cause = bcd_pkg::CAUSE_FINAL_TEXT;
            end
        end

        n_s100 = s_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s100      <= '0;
            r_utf       <= bcd_pkg::UTF_NONE;
            r_done      <= 1'b0;
            r_bom       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                if (i_cls.last) begin
                    r_s100 <= '0;
                    r_utf  <= bcd_pkg::UTF_NONE;
                    r_done <= 1'b0;
                    r_bom  <= 2'd0;
                end else begin
                    r_s100 <= n_s100;
                    r_utf  <= n_utf;
                    r_done <= n_done;
                    r_bom  <= n_bom;
                end
            end
            if (go && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_out <= res;
        end
    end

endmodule

// File: sv/binary_content_detector_top.sv
// Binary/text detector: one buffer byte per input word, with the scanned
// length repeated on every word. A buffer ends at the byte whose position
// reaches that length; the next word then starts a new buffer.
// Input channel: i_in_valid / o_in_stall / i_in_data. Output channel:
// o_out_valid / i_out_stall / o_out_data, at most one word per buffer,
// carrying verdict, cause and byte index. Bytes after a verdict are
// swallowed without output.
// Config: i_cfg_we with i_cfg_idx 0 = min bytes before early decision,
// 1 = percent limit. Write only while the block is idle.
// Throughput: one byte per cycle while o_in_stall is low. A verdict byte
// passes the queue and is registered by the back stage. The front stage
// computes the ratio threshold (one multiply) and classifies the byte; the
// back stage owns the count and UTF-8 state and the output register.
// Reset (synchronous, active low) restores default config, clears buffer
// state and empties the queue. When the receiver stalls, the output word
// holds; the FIFO_DEPTH-entry queue keeps filling, then o_in_stall rises.
module binary_content_detector_top #(
    parameter int FIFO_DEPTH = bcd_pkg::FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [bcd_pkg::LEN_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  bcd_pkg::t_in_word          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output bcd_pkg::t_out_word         o_out_data
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    bcd_pkg::t_cls cls_in;
    bcd_pkg::t_cls cls_out;

    bcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cls      (cls_in)
    );

    bcd_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (cls_out)
    );

    bcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cls       (cls_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: sv/bcd_checker.sv
module bcd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bcd_pkg::t_out_word o_out_data
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed under stall");

    // queue only fills behind a held output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no output pending");

    // byte order mark verdict is text at the third byte
    a_bom_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.decision_cause == bcd_pkg::CAUSE_BOM |->
            !o_out_data.verdict && o_out_data.decision_index == 10'd2)
        else $error("bad byte order mark verdict");

    // text only from mark or final test
    a_verdict_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.verdict ==
            !(o_out_data.decision_cause == bcd_pkg::CAUSE_BOM ||
              o_out_data.decision_cause == bcd_pkg::CAUSE_FINAL_TEXT)))
        else $error("verdict does not match cause");

endmodule

bind binary_content_detector_top bcd_checker u_bcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
